/* hw/rtl/sis_pkg.sv */
`default_nettype none

package sis_pkg;

  // input field widths
  localparam int unsigned OPCODE_W = 1;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 6;

  // output field widths
  localparam int unsigned POS_W    = 7;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 2;

  // stream word widths
  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 48;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_INSERT = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_READ   = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic latch;       // take the input word, load slot pointer from count
    logic start_ins;   // read top entry, begin the downward scan
    logic start_rd;    // read entry at requested index
    logic shift;       // move entry up one slot, read the next lower one
    logic put;         // write value at slot pointer, bump count
    logic reject_full; // insert refused, store full
    logic reject_rd;   // read refused, index not below count
    logic cap_rd;      // capture read data
    logic ld_out;      // move staged result into output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_read;  // latched opcode is a read
    logic full;     // count equals depth
    logic empty;    // count is zero
    logic idx_ok;   // read index below count
    logic gt;       // entry under test is greater than value
    logic j_one;    // slot pointer is one
    logic out_free; // output register can take a result
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/sorted_insert_store.sv */
`default_nettype none

// sorted store of signed 32-bit values with a running count
//
// input stream: one word per command. tuser selects insert or read; tdata
// carries the value to insert and the index to read. output stream: one word
// per command with position, read value, count and a status code in tuser.
// an insert scans down from the top entry, moving each greater entry up one
// slot, and drops the value into the gap, so equal values land after older
// ones. the single memory port pair sets the cost: an insert moves one
// entry per scan step, so its cost grows with the entries above its
// position; a read, a refused command and an insert into an empty store
// skip the scan; output valid rises together with input ready.
// one command is worked at a time; a new word is taken once the last result
// has moved into the output register, even while that word still waits.
// reset empties the store (count zero) and clears the output valid; entry
// contents are not cleared. a stalled receiver holds the output word, and a
// finished result then waits in its staging register until the output word
// is taken, with the input held off meanwhile.
module sorted_insert_store #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // value [31:0], index [37:32], zero pad
  input  wire logic [sis_pkg::S_DATA_W-1:0] s_tdata,
  // opcode [0]
  input  wire logic [sis_pkg::OPCODE_W-1:0] s_tuser,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // position [6:0], read_value [38:7], count [45:39], zero pad
  output logic      [sis_pkg::M_DATA_W-1:0] m_tdata,
  // status [1:0]
  output logic      [sis_pkg::STATUS_W-1:0] m_tuser
);

  sis_pkg::cmd_t cmd;
  sis_pkg::sts_t sts;

  // sequencer
  sis_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // store, scan pointer and result registers
  sis_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

`default_nettype wire

/* hw/rtl/sis_ram.sv */
`default_nettype none

module sis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/sis_ctrl.sv */
`default_nettype none

module sis_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire sis_pkg::sts_t sts,
  output sis_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_RDW   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (!sts.is_read) begin
          if (sts.full) begin
            cmd.reject_full = 1'b1;
            state_next      = S_FIN;
          end else if (sts.empty) begin
            cmd.put    = 1'b1;
            state_next = S_FIN;
          end else begin
            cmd.start_ins = 1'b1;
            state_next    = S_SCAN;
          end
        end else if (sts.idx_ok) begin
          cmd.start_rd = 1'b1;
          state_next   = S_RDW;
        end else begin
          cmd.reject_rd = 1'b1;
          state_next    = S_FIN;
        end
      end
      S_SCAN: begin
        if (sts.gt) begin
          cmd.shift  = 1'b1;
          state_next = sts.j_one ? S_PLACE : S_SCAN;
        end else begin
          cmd.put    = 1'b1;
          state_next = S_FIN;
        end
      end
      S_PLACE: begin
        cmd.put    = 1'b1;
        state_next = S_FIN;
      end
      S_RDW: begin
        cmd.cap_rd = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/sis_dp.sv */
`default_nettype none

module sis_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [sis_pkg::S_DATA_W-1:0]    s_tdata,
  input  wire logic [sis_pkg::OPCODE_W-1:0]    s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [sis_pkg::M_DATA_W-1:0]    m_tdata,
  output logic      [sis_pkg::STATUS_W-1:0]    m_tuser,
  input  wire sis_pkg::cmd_t                   cmd,
  output sis_pkg::sts_t                        sts
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > sis_pkg::INDEX_W) ? CW : sis_pkg::INDEX_W;
  localparam int unsigned IW = (AW > sis_pkg::INDEX_W) ? AW : sis_pkg::INDEX_W;

  // latched input word
  logic [sis_pkg::OPCODE_W-1:0] op_r;
  logic [sis_pkg::VALUE_W-1:0]  val_r;
  logic [sis_pkg::INDEX_W-1:0]  idx_r;

  // store state and scan pointer (slot the value would take)
  logic [CW-1:0] cnt;
  logic [CW-1:0] j;

  // staged result
  logic [sis_pkg::POS_W-1:0]    pos_r;
  logic [sis_pkg::VALUE_W-1:0]  rd_r;
  logic [sis_pkg::STATUS_W-1:0] st_r;

  // output register
  logic [sis_pkg::POS_W-1:0]    out_pos;
  logic [sis_pkg::VALUE_W-1:0]  out_rd;
  logic [sis_pkg::COUNT_W-1:0]  out_cnt;
  logic [sis_pkg::STATUS_W-1:0] out_st;

  // memory ports
  logic                         we;
  logic [AW-1:0]                waddr;
  logic [sis_pkg::VALUE_W-1:0]  wdata;
  logic [AW-1:0]                raddr;
  logic [sis_pkg::VALUE_W-1:0]  rdata;

  // widened copies for truncation to output widths
  logic [CW+sis_pkg::POS_W-1:0] j_w;
  logic [CW+sis_pkg::POS_W-1:0] cnt_w;
  logic [IW-1:0]                idx_a;
  logic [CW-1:0]                j_m1;
  logic [CW-1:0]                j_m2;
  logic [CW-1:0]                cnt_m1;

  assign j_w    = {{sis_pkg::POS_W{1'b0}}, j};
  assign cnt_w  = {{sis_pkg::POS_W{1'b0}}, cnt};
  assign idx_a  = IW'(idx_r);
  assign j_m1   = j - CW'(1);
  assign j_m2   = j - CW'(2);
  assign cnt_m1 = cnt - CW'(1);

  // status to controller
  assign sts.is_read  = (op_r == sis_pkg::OP_READ);
  assign sts.full     = (cnt == CW'(DEPTH));
  assign sts.empty    = (cnt == '0);
  assign sts.idx_ok   = (XW'(idx_r) < XW'(cnt));
  assign sts.gt       = ($signed(rdata) > $signed(val_r));
  assign sts.j_one    = (j == CW'(1));
  assign sts.out_free = !m_tvalid || m_tready;

  // memory address and data selection
  always_comb begin
    we    = 1'b0;
    waddr = j[AW-1:0];
    wdata = val_r;
    raddr = j_m2[AW-1:0];
    if (cmd.start_ins) begin
      raddr = cnt_m1[AW-1:0];
    end else if (cmd.start_rd) begin
      raddr = idx_a[AW-1:0];
    end
    if (cmd.shift) begin
      we    = 1'b1;
      wdata = rdata;
    end else if (cmd.put) begin
      we = 1'b1;
    end
  end

  sis_ram #(
    .WIDTH(sis_pkg::VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // input latch, scan pointer and staged result
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= s_tuser;
      val_r <= s_tdata[sis_pkg::VALUE_W-1:0];
      idx_r <= s_tdata[sis_pkg::VALUE_W +: sis_pkg::INDEX_W];
      j     <= cnt;
    end
    if (cmd.shift) begin
      j <= j_m1;
    end
    if (cmd.put) begin
      pos_r <= j_w[sis_pkg::POS_W-1:0];
      rd_r  <= '0;
      st_r  <= sis_pkg::ST_OK;
    end
    if (cmd.reject_full) begin
      pos_r <= '0;
      rd_r  <= '0;
      st_r  <= sis_pkg::ST_FULL;
    end
    if (cmd.reject_rd) begin
      pos_r <= sis_pkg::POS_W'(idx_r);
      rd_r  <= '0;
      st_r  <= sis_pkg::ST_RANGE;
    end
    if (cmd.cap_rd) begin
      pos_r <= sis_pkg::POS_W'(idx_r);
      rd_r  <= rdata;
      st_r  <= sis_pkg::ST_OK;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.put) begin
      cnt <= cnt + CW'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.ld_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_pos <= pos_r;
      out_rd  <= rd_r;
      out_cnt <= cnt_w[sis_pkg::COUNT_W-1:0];
      out_st  <= st_r;
    end
  end

  assign m_tdata = {2'b00, out_cnt, out_rd, out_pos};
  assign m_tuser = out_st;

endmodule

`default_nettype wire

/* hw/rtl/sis_checker.sv */
`default_nettype none

module sis_checker #(
  parameter int unsigned DEPTH = 64
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [sis_pkg::M_DATA_W-1:0] m_tdata,
  input wire logic [sis_pkg::STATUS_W-1:0] m_tuser
);

  // output word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // no command is taken straight after another
  a_in_gap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on consecutive cycles");

  // a refused insert reports zero position and value
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == sis_pkg::ST_FULL |-> m_tdata[38:0] == 39'd0)
    else $error("refused insert with non-zero fields");

  // a refused read reports zero value and a count not above its index
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == sis_pkg::ST_RANGE |->
      m_tdata[38:7] == 32'd0 && (DEPTH > 127 || m_tdata[45:39] <= m_tdata[6:0]))
    else $error("refused read with bad fields");

  // reset empties the output
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind sorted_insert_store sis_checker #(.DEPTH(DEPTH)) u_sis_checker (.*);

`default_nettype wire
